[rtl/core/psv_pkg.sv]
package psv_pkg;

  // Number of motors held in the state memory.
  localparam int NumMotors = 3;
  localparam int MotorAw   = (NumMotors > 1) ? $clog2(NumMotors) : 1;
  // Motors that own a counts-per-revolution register.
  localparam int NumCprRegs = 3;

  // Stream and configuration widths; the tdata widths are padded to whole bytes.
  localparam int InTdataW  = 48;
  localparam int InTuserW  = 3;
  localparam int OutTdataW = 32;
  localparam int OutTuserW = 1;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 22;

  // Input command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] CFG_CPR0   = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_CPR1   = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_CPR2   = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_PGAIN  = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_DGAIN  = 3'd4;
  localparam logic [CfgIndexW-1:0] CFG_SWAP   = 3'd5;
  localparam logic [CfgIndexW-1:0] CFG_NARROW = 3'd6;

  // Configuration reset values.
  localparam logic [21:0] CprReset0   = 22'd352000;
  localparam logic [21:0] CprReset1   = 22'd8000;
  localparam logic [21:0] CprReset2   = 22'd30000;
  localparam logic [7:0]  PGainReset  = 8'd8;
  localparam logic [7:0]  DGainReset  = 8'd12;
  localparam logic [2:0]  SwapReset   = 3'd2;
  localparam logic [2:0]  NarrowReset = 3'd4;

  // Servo constants.
  localparam logic [11:0] DutyMax     = 12'd2200;
  localparam logic [11:0] DutyMin     = 12'd500;
  localparam logic [3:0]  SettleTicks = 4'd12;
  localparam logic [3:0]  SettleMax   = 4'd15;

  // Rounded division by 360: add 180, drop three bits, then divide by 45
  // through a reciprocal that may come out one low.
  localparam logic [33:0] RoundBias = 34'd180;
  localparam logic [30:0] Recip45   = 31'd1527099483;
  localparam logic [31:0] Div45     = 32'd45;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_START,
    KIND_SETTLE,
    KIND_DRIVE
  } item_kind_e;

  typedef struct packed {
    logic signed [31:0] target;
    logic        [31:0] prev;
    logic        [3:0]  settle;
    logic               active;
  } motor_state_t;

  typedef struct packed {
    logic [NumCprRegs-1:0][21:0] cpr;
    logic [7:0]                  prop_gain;
    logic [7:0]                  deriv_gain;
    logic [2:0]                  swap_mask;
    logic [2:0]                  narrow_mask;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic        [1:0]  motor;
    logic signed [11:0] angle_deg;
    logic signed [31:0] encoder_count;
  } in_item_t;

  typedef struct packed {
    logic        drive_valid;
    logic [11:0] right_duty;
    logic [11:0] left_duty;
    logic        clear_counter;
    logic        moving;
    logic        move_done;
  } result_t;

  function automatic logic motor_ok(input logic [1:0] m);
    return (int'(m) < NumMotors) && (int'(m) < NumCprRegs);
  endfunction

endpackage

[rtl/core/psv_ram.sv]
module psv_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/psv_cfg.sv]
module psv_cfg import psv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_valid_i,
  output logic                 wr_ready_o,
  input  logic [CfgIndexW-1:0] wr_index_i,
  input  logic [CfgDataW-1:0]  wr_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  assign wr_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cpr[0]       <= CprReset0;
      cfg_q.cpr[1]       <= CprReset1;
      cfg_q.cpr[2]       <= CprReset2;
      cfg_q.prop_gain    <= PGainReset;
      cfg_q.deriv_gain   <= DGainReset;
      cfg_q.swap_mask    <= SwapReset;
      cfg_q.narrow_mask  <= NarrowReset;
    end else if (wr_valid_i) begin
      case (wr_index_i)
        CFG_CPR0:   cfg_q.cpr[0]      <= wr_data_i;
        CFG_CPR1:   cfg_q.cpr[1]      <= wr_data_i;
        CFG_CPR2:   cfg_q.cpr[2]      <= wr_data_i;
        CFG_PGAIN:  cfg_q.prop_gain   <= wr_data_i[7:0];
        CFG_DGAIN:  cfg_q.deriv_gain  <= wr_data_i[7:0];
        CFG_SWAP:   cfg_q.swap_mask   <= wr_data_i[2:0];
        CFG_NARROW: cfg_q.narrow_mask <= wr_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/psv_pipe.sv]
module psv_pipe import psv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output result_t  out_item_o,
  input  cfg_t     cfg_i
);

  localparam int StateW = $bits(motor_state_t);

  logic adv;
  logic in_acc;
  logic hazard;

  // Stage 1: item plus state read from memory.
  logic         v1_q;
  in_item_t     it1_q;
  logic [StateW-1:0] rd_raw;
  motor_state_t rd_state;
  motor_state_t cur_state;
  logic         ok1;
  logic [MotorAw-1:0] addr1;
  logic signed [32:0] err1;
  logic        [31:0] diff1;
  logic signed [31:0] d1;
  logic         near1;
  logic [3:0]   settle_inc1;
  logic [3:0]   settle_new1;
  logic         settled1;
  item_kind_e   kind1;
  motor_state_t rec1;
  logic         wr1;
  logic [21:0]  cpr1;
  logic signed [41:0] pm1;
  logic signed [40:0] dm1;
  logic signed [34:0] num1;

  // Stage 2: products.
  logic         v2_q;
  item_kind_e   kind2_q;
  logic [1:0]   motor2_q;
  logic         wr2_q;
  motor_state_t rec2_q;
  logic         swap2_q;
  logic signed [41:0] pm2_q;
  logic signed [40:0] dm2_q;
  logic signed [34:0] num2_q;
  logic signed [42:0] u2;
  logic [34:0]  abs2;
  logic [33:0]  x2;
  logic [30:0]  y2;
  logic [61:0]  prod2;

  // Stage 3: duty shaping, target correction, write back.
  logic         v3_q;
  item_kind_e   kind3_q;
  logic [1:0]   motor3_q;
  logic         wr3_q;
  motor_state_t rec3_q;
  logic         swap3_q;
  logic signed [42:0] u3_q;
  logic [30:0]  y3_q;
  logic [25:0]  q3_q;
  logic         neg3_q;
  logic [31:0]  q45;
  logic [31:0]  rem3;
  logic [25:0]  qfix3;
  logic signed [31:0] target3;
  motor_state_t wdata;
  logic         we;
  logic [MotorAw-1:0] waddr;
  logic [42:0]  mag3;
  logic [11:0]  duty3;
  logic         pos3;
  logic         negd3;
  logic [11:0]  pos_duty3;
  logic [11:0]  neg_duty3;
  result_t      res3;

  // Last write, for forwarding into a read that overlapped it.
  logic         w_v_q;
  logic [1:0]   w_motor_q;
  motor_state_t w_state_q;

  logic [NumMotors-1:0] written_q;

  logic    out_valid_q;
  result_t out_q;

  assign adv    = !out_valid_q || out_ready_i;
  // A tick must not read state while a start for its motor still computes.
  assign hazard = (in_item_i.cmd == CMD_TICK) &&
                  ((v1_q && it1_q.cmd == CMD_START && it1_q.motor == in_item_i.motor) ||
                   (v2_q && kind2_q == KIND_START && motor2_q == in_item_i.motor) ||
                   (v3_q && kind3_q == KIND_START && motor3_q == in_item_i.motor));
  assign in_ready_o = adv && !hazard;
  assign in_acc     = in_valid_i && in_ready_o;

  psv_ram #(
    .Width (StateW),
    .Depth (NumMotors)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (in_acc && motor_ok(in_item_i.motor)),
    .raddr_i (MotorAw'(in_item_i.motor)),
    .rdata_o (rd_raw)
  );

  // ---------------- Stage 1 ----------------
  always_comb begin
    ok1      = motor_ok(it1_q.motor);
    addr1    = MotorAw'(it1_q.motor);
    rd_state = written_q[addr1] ? motor_state_t'(rd_raw) : '0;
    cur_state = rd_state;
    if (w_v_q && w_motor_q == it1_q.motor) begin
      cur_state = w_state_q;
    end
    if (v3_q && wr3_q && motor3_q == it1_q.motor) begin
      cur_state = rec3_q;
    end
    if (v2_q && wr2_q && motor2_q == it1_q.motor) begin
      cur_state = rec2_q;
    end
  end

  always_comb begin
    err1  = $signed({cur_state.target[31], cur_state.target}) -
            $signed({it1_q.encoder_count[31], it1_q.encoder_count});
    diff1 = it1_q.encoder_count - cur_state.prev;
    d1    = cfg_i.narrow_mask[it1_q.motor] ? $signed({{16{diff1[15]}}, diff1[15:0]})
                                           : $signed(diff1);
    near1 = (err1 >= -33'sd2) && (err1 <= 33'sd2) && (d1 >= -32'sd8) && (d1 <= 32'sd8);
    settle_inc1 = (cur_state.settle < SettleMax) ? cur_state.settle + 4'd1
                                                 : cur_state.settle;
    settle_new1 = near1 ? settle_inc1 : 4'd0;
    settled1    = near1 && (settle_new1 >= SettleTicks);
  end

  always_comb begin
    kind1 = KIND_NONE;
    rec1  = cur_state;
    wr1   = 1'b0;
    if (ok1) begin
      if (it1_q.cmd == CMD_START) begin
        kind1       = KIND_START;
        rec1        = '0;
        rec1.active = 1'b1;
        wr1         = 1'b1;
      end else if (cur_state.active) begin
        wr1 = 1'b1;
        if (settled1) begin
          kind1       = KIND_SETTLE;
          rec1        = '0;
          rec1.settle = settle_new1;
        end else begin
          kind1       = KIND_DRIVE;
          rec1.prev   = it1_q.encoder_count;
          rec1.settle = settle_new1;
        end
      end
    end
  end

  always_comb begin
    case (it1_q.motor)
      2'd1:    cpr1 = cfg_i.cpr[1];
      2'd2:    cpr1 = cfg_i.cpr[2];
      default: cpr1 = cfg_i.cpr[0];
    endcase
    pm1  = $signed({1'b0, cfg_i.prop_gain}) * err1;
    dm1  = $signed({1'b0, cfg_i.deriv_gain}) * d1;
    num1 = it1_q.angle_deg * $signed({1'b0, cpr1});
  end

  // ---------------- Stage 2 ----------------
  always_comb begin
    u2    = $signed({pm2_q[41], pm2_q}) - $signed({{2{dm2_q[40]}}, dm2_q});
    abs2  = num2_q[34] ? (35'd0 - num2_q) : num2_q;
    x2    = abs2[33:0] + RoundBias;
    y2    = x2[33:3];
    prod2 = 62'(y2) * 62'(Recip45);
  end

  // ---------------- Stage 3 ----------------
  always_comb begin
    q45     = {1'b0, q3_q, 5'b0} + {3'b0, q3_q, 3'b0} + {4'b0, q3_q, 2'b0} + 32'(q3_q);
    rem3    = 32'(y3_q) - q45;
    qfix3   = q3_q + ((rem3 >= Div45) ? 26'd1 : 26'd0);
    target3 = neg3_q ? $signed(32'd0 - 32'(qfix3)) : $signed(32'(qfix3));
    wdata   = rec3_q;
    if (kind3_q == KIND_START) begin
      wdata.target = target3;
    end
    we    = adv && v3_q && wr3_q;
    waddr = MotorAw'(motor3_q);
  end

  always_comb begin
    mag3  = u3_q[42] ? (43'd0 - u3_q) : u3_q;
    if (mag3 > 43'(DutyMax)) begin
      duty3 = DutyMax;
    end else if (mag3 != '0 && mag3 < 43'(DutyMin)) begin
      duty3 = DutyMin;
    end else begin
      duty3 = mag3[11:0];
    end
    pos3      = !u3_q[42] && (u3_q != '0);
    negd3     = u3_q[42];
    pos_duty3 = pos3 ? duty3 : 12'd0;
    neg_duty3 = negd3 ? duty3 : 12'd0;
  end

  always_comb begin
    res3 = '0;
    case (kind3_q)
      KIND_START: begin
        res3.clear_counter = 1'b1;
        res3.moving        = 1'b1;
      end
      KIND_SETTLE: begin
        res3.drive_valid   = 1'b1;
        res3.clear_counter = 1'b1;
        res3.move_done     = 1'b1;
      end
      KIND_DRIVE: begin
        res3.drive_valid = 1'b1;
        res3.moving      = 1'b1;
        res3.right_duty  = swap3_q ? neg_duty3 : pos_duty3;
        res3.left_duty   = swap3_q ? pos_duty3 : neg_duty3;
      end
      default: res3 = '0;
    endcase
  end

  // ---------------- Registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      w_v_q       <= 1'b0;
      written_q   <= '0;
    end else begin
      if (adv) begin
        v1_q        <= in_acc;
        v2_q        <= v1_q;
        v3_q        <= v2_q;
        out_valid_q <= v3_q;
      end
      if (we) begin
        w_v_q            <= 1'b1;
        written_q[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it1_q    <= in_item_i;
      kind2_q  <= kind1;
      motor2_q <= it1_q.motor;
      wr2_q    <= wr1;
      rec2_q   <= rec1;
      swap2_q  <= cfg_i.swap_mask[it1_q.motor];
      pm2_q    <= pm1;
      dm2_q    <= dm1;
      num2_q   <= num1;
      kind3_q  <= kind2_q;
      motor3_q <= motor2_q;
      wr3_q    <= wr2_q;
      rec3_q   <= rec2_q;
      swap3_q  <= swap2_q;
      u3_q     <= u2;
      y3_q     <= y2;
      q3_q     <= prod2[61:36];
      neg3_q   <= num2_q[34];
      out_q    <= res3;
    end
    if (we) begin
      w_motor_q <= motor3_q;
      w_state_q <= wdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---------------- Assertions ----------------
  a_no_start_hazard_s2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && it1_q.cmd == CMD_TICK && v2_q && kind2_q == KIND_START)
      |-> (motor2_q != it1_q.motor))
    else $error("tick read state under a start in stage 2");

  a_no_start_hazard_s3 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && it1_q.cmd == CMD_TICK && v3_q && kind3_q == KIND_START)
      |-> (motor3_q != it1_q.motor))
    else $error("tick read state under a start in stage 3");

  a_one_side_driven : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.right_duty != 12'd0 && out_item_o.left_duty != 12'd0))
    else $error("both PWM channels driven");

  a_start_written : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && kind3_q == KIND_START) |=> (w_state_q.active && written_q[$past(waddr)]))
    else $error("start did not arm the motor entry");

endmodule

[rtl/core/pd_position_servo_three_axis_top.sv]
// A result is presented on the m_axis side once its input transaction has passed the
// state read, multiply, shape/write back and output register stages.
// Throughput: one transaction per cycle while m_axis takes results; a tick that follows
// a start for the same motor waits until the start's count target has been written back.
// Reset (rst_ni low, asynchronous): pipeline and output emptied, every motor idle with
// zero state, configuration registers back to their default values; no clearing pass.
module pd_position_servo_three_axis_top import psv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  // Input stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata, lowest bit up: angle_deg[11:0], encoder_count[43:12], zero pad[47:44].
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // tuser, lowest bit up: cmd[0], motor[2:1].
  input  logic [InTuserW-1:0]  s_axis_tuser,

  // Result stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata, lowest bit up: right_duty[11:0], left_duty[23:12], clear_counter[24],
  // moving[25], move_done[26], zero pad[31:27].
  output logic [OutTdataW-1:0] m_axis_tdata,
  // tuser: drive_valid[0].
  output logic [OutTuserW-1:0] m_axis_tuser,

  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  cfg_t     cfg;
  in_item_t in_item;
  result_t  result;

  // Unpack the input transaction into the item fields.
  assign in_item.cmd           = s_axis_tuser[0];
  assign in_item.motor         = s_axis_tuser[2:1];
  assign in_item.angle_deg     = s_axis_tdata[11:0];
  assign in_item.encoder_count = s_axis_tdata[43:12];

  // Configuration registers. Writes are taken every cycle; the host must only write
  // while no transaction is in flight, and the block itself does not enforce this.
  psv_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_valid_i),
    .wr_ready_o (cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Per-motor state lives in a small synchronous memory inside the pipeline. Each
  // item reads its motor's entry, updates it by stage 3 and writes it back there;
  // younger items see in-flight updates through forwarding.
  psv_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (result),
    .cfg_i       (cfg)
  );

  // Pack the result transaction.
  assign m_axis_tdata = {5'b0, result.move_done, result.moving, result.clear_counter,
                         result.left_duty, result.right_duty};
  assign m_axis_tuser = result.drive_valid;

endmodule
